// ===== rtl/lcas_pkg.sv =====
// Shared types, widths and constants of the load cell averaging block.
package lcas_pkg;

	// Depth of the moving average ring.
	localparam int AVERAGE_DEPTH = 16;
	localparam int LOG_DEPTH     = $clog2(AVERAGE_DEPTH);
	localparam int IDX_W         = LOG_DEPTH;
	localparam int CNT_W         = $clog2(AVERAGE_DEPTH + 1);

	// Fixed field widths.
	localparam int SMP_W  = 24;
	localparam int DIFF_W = SMP_W + 1;
	localparam int GAIN_W = 28;
	localparam int PROD_W = DIFF_W + GAIN_W;
	localparam int WGT_W  = 32;
	localparam int THR_W  = 16;
	localparam int CC_W   = 8;

	// Ring sum magnitude, signed sum and the shared adder width.
	localparam int MAG_W  = WGT_W + LOG_DEPTH;
	localparam int SUM_W  = MAG_W + 1;
	localparam int ALU_W  = SUM_W + 1;
	localparam int DCNT_W = $clog2(MAG_W);

	// Operations of the shared adder.
	localparam logic ALU_ADD = 1'b0;
	localparam logic ALU_SUB = 1'b1;

	typedef struct packed {
		logic                    cmd;
		logic signed [SMP_W-1:0] raw_sample;
	} in_item_t;

	typedef struct packed {
		logic                    accepted;
		logic signed [WGT_W-1:0] average_weight;
		logic signed [WGT_W-1:0] stable_weight;
		logic                    is_stable;
	} out_item_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] tare_offset;
		logic [GAIN_W-1:0]       gain_reciprocal;
		logic signed [WGT_W-1:0] min_valid_weight;
		logic signed [WGT_W-1:0] max_valid_weight;
		logic [THR_W-1:0]        calm_threshold;
		logic [CC_W-1:0]         calm_needed;
	} cfg_t;

	typedef struct packed {
		logic                    op;
		logic signed [ALU_W-1:0] a;
		logic signed [ALU_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic signed [ALU_W-1:0] y;
		logic                    neg;
	} alu_rsp_t;

endpackage

// ===== rtl/load_cell_average_stability.sv =====
// Load cell moving average with stability detection: top level with register port.
//
// Samples arrive on the sample channel (valid/ready) as a command bit and a
// signed 24-bit ADC reading; one result item per sample leaves on the result
// channel (valid/ready) with the accepted flag, the moving average, the
// latched stable weight and the stability flag.
// An accepted sample's result becomes valid in the same cycle that the block
// is ready again, so a new sample is taken only once the last one is through;
// the restoring division of the ring sum by the fill count on the shared
// adder takes the largest share of that work. A rejected sample skips the ring
// update and the division, and a clear command skips all arithmetic.
// The result sits in an output register, so the next sample is taken while a
// result still waits; a stalled receiver holds the block only when a second
// result is ready before the first is taken.
// Reset clears the averaging state and loads the register defaults; the ring
// memory needs no clearing pass, as entries are read only after being written.
// Registers are written through the APB-style port at byte addresses 4*i and
// should be written only while the block is idle.
module load_cell_average_stability import lcas_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_ready,
	input  in_item_t    sample,
	output logic        result_valid,
	input  logic        result_ready,
	output out_item_t   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic [2:0] REG_TARE   = 3'd0;
	localparam logic [2:0] REG_GAIN   = 3'd1;
	localparam logic [2:0] REG_MIN    = 3'd2;
	localparam logic [2:0] REG_MAX    = 3'd3;
	localparam logic [2:0] REG_THRESH = 3'd4;
	localparam logic [2:0] REG_NEEDED = 3'd5;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tare_offset      <= '0;
			cfg_q.gain_reciprocal  <= GAIN_W'(65536);
			cfg_q.min_valid_weight <= -32'sd16000;
			cfg_q.max_valid_weight <= 32'sd80000;
			cfg_q.calm_threshold   <= THR_W'(8);
			cfg_q.calm_needed      <= CC_W'(5);
		end else if (wr_en) begin
			case (reg_idx)
				REG_TARE:   cfg_q.tare_offset      <= pwdata[SMP_W-1:0];
				REG_GAIN:   cfg_q.gain_reciprocal  <= pwdata[GAIN_W-1:0];
				REG_MIN:    cfg_q.min_valid_weight <= pwdata;
				REG_MAX:    cfg_q.max_valid_weight <= pwdata;
				REG_THRESH: cfg_q.calm_threshold   <= pwdata[THR_W-1:0];
				REG_NEEDED: cfg_q.calm_needed      <= pwdata[CC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (reg_idx)
			REG_TARE:   prdata = 32'(cfg_q.tare_offset);
			REG_GAIN:   prdata = 32'(cfg_q.gain_reciprocal);
			REG_MIN:    prdata = cfg_q.min_valid_weight;
			REG_MAX:    prdata = cfg_q.max_valid_weight;
			REG_THRESH: prdata = 32'(cfg_q.calm_threshold);
			REG_NEEDED: prdata = 32'(cfg_q.calm_needed);
			default:    prdata = '0;
		endcase
	end

	lcas_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// The sequencer leaves idle as soon as it takes a sample.
	assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("block still ready after taking a sample");

	// A stable result always reports the average as the stable weight.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.is_stable |-> result.stable_weight == result.average_weight)
		else $error("stable weight differs from average while stable");

	// A fresh result is handed over just as the sequencer returns to idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> sample_ready)
		else $error("result loaded while sequencer busy");

endmodule

// ===== rtl/lcas_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module lcas_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/lcas_alu.sv =====
// Shared add/subtract unit with a sign flag, used by every add, subtract and compare step.
module lcas_alu import lcas_pkg::*; (
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	// One wide adder; subtraction inverts the second operand.
	always_comb begin
		if (req.op == ALU_SUB) begin
			rsp.y = req.a - req.b;
		end else begin
			rsp.y = req.a + req.b;
		end
		rsp.neg = rsp.y[ALU_W-1];
	end

endmodule

// ===== rtl/lcas_core.sv =====
// Sequencer, working registers and output register of the averaging block.
module lcas_core import lcas_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      sample_valid,
	output logic      sample_ready,
	input  in_item_t  sample,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_DIFF = 5'd1;
	localparam logic [4:0] S_MAGN = 5'd2;
	localparam logic [4:0] S_MUL  = 5'd3;
	localparam logic [4:0] S_SAT  = 5'd4;
	localparam logic [4:0] S_NEGW = 5'd5;
	localparam logic [4:0] S_LOW  = 5'd6;
	localparam logic [4:0] S_HIGH = 5'd7;
	localparam logic [4:0] S_SUB  = 5'd8;
	localparam logic [4:0] S_ADD  = 5'd9;
	localparam logic [4:0] S_ABSS = 5'd10;
	localparam logic [4:0] S_DIV  = 5'd11;
	localparam logic [4:0] S_QNEG = 5'd12;
	localparam logic [4:0] S_DLT  = 5'd13;
	localparam logic [4:0] S_DABS = 5'd14;
	localparam logic [4:0] S_CALM = 5'd15;
	localparam logic [4:0] S_DONE = 5'd16;

	logic [4:0] state_q;

	// Averaging state.
	logic [IDX_W-1:0]        idx_q;
	logic                    full_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [WGT_W-1:0] prev_q;
	logic [CC_W-1:0]         cc_q;
	logic signed [WGT_W-1:0] held_avg_q;
	logic signed [WGT_W-1:0] held_stab_q;
	logic                    stable_q;
	logic [DCNT_W-1:0]       div_cnt_q;
	logic                    low_ok_q;
	logic                    res_valid_q;

	// Working registers.
	logic signed [SMP_W-1:0] raw_q;
	logic signed [ALU_W-1:0] acc_q;
	logic                    neg_q;
	logic [DIFF_W-1:0]       mag_q;
	logic [PROD_W-1:0]       prod_q;
	logic [MAG_W-1:0]        dvd_q;
	logic [CNT_W-1:0]        rem_q;
	logic                    sum_neg_q;
	logic signed [WGT_W-1:0] avg_q;
	out_item_t               pend_q;
	out_item_t               res_q;

	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;
	logic [WGT_W-1:0]  old_entry;
	logic              take_in;
	logic              load_out;
	logic              wrap;
	logic [CNT_W:0]    rem_shift;
	logic [CC_W-1:0]   cc_next;
	logic              stable_next;

	lcas_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	lcas_ram #(
		.WIDTH (WGT_W),
		.DEPTH (AVERAGE_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (state_q == S_SUB),
		.waddr (idx_q),
		.wdata (acc_q[WGT_W-1:0]),
		.re    (state_q == S_MAGN),
		.raddr (idx_q),
		.rdata (old_entry)
	);

	assign sample_ready = (state_q == S_IDLE);
	assign take_in      = sample_valid && sample_ready;
	assign load_out     = (state_q == S_DONE) && (!res_valid_q || result_ready);
	assign result_valid = res_valid_q;
	assign result       = res_q;
	assign wrap         = (idx_q == IDX_W'(AVERAGE_DEPTH - 1));
	assign rem_shift    = {rem_q, dvd_q[MAG_W-1]};

	// Calm count and stability for the step that closes an accepted sample.
	always_comb begin
		if (alu_rsp.neg) begin
			cc_next = (cc_q == {CC_W{1'b1}}) ? cc_q : cc_q + CC_W'(1);
		end else begin
			cc_next = '0;
		end
		stable_next = (cc_next >= cfg.calm_needed);
	end

	// Operand selection for the shared adder in each step.
	always_comb begin
		alu_req.op = ALU_SUB;
		alu_req.a  = '0;
		alu_req.b  = '0;
		case (state_q)
			S_DIFF: begin
				alu_req.a = ALU_W'(raw_q);
				alu_req.b = ALU_W'(cfg.tare_offset);
			end
			S_MAGN, S_NEGW, S_DABS: begin
				alu_req.b = acc_q;
			end
			S_LOW: begin
				alu_req.a = acc_q;
				alu_req.b = ALU_W'(cfg.min_valid_weight);
			end
			S_HIGH: begin
				alu_req.a = ALU_W'(cfg.max_valid_weight);
				alu_req.b = acc_q;
			end
			S_SUB: begin
				alu_req.a = ALU_W'(sum_q);
				alu_req.b = full_q ? ALU_W'($signed(old_entry)) : '0;
			end
			S_ADD: begin
				alu_req.op = ALU_ADD;
				alu_req.a  = ALU_W'(sum_q);
				alu_req.b  = acc_q;
			end
			S_ABSS: begin
				alu_req.b = ALU_W'(sum_q);
			end
			S_DIV: begin
				alu_req.a = ALU_W'(rem_shift);
				alu_req.b = ALU_W'(cnt_q);
			end
			S_QNEG: begin
				alu_req.b = ALU_W'(dvd_q);
			end
			S_DLT: begin
				alu_req.a = ALU_W'(avg_q);
				alu_req.b = ALU_W'(prev_q);
			end
			S_CALM: begin
				alu_req.a = acc_q;
				alu_req.b = ALU_W'(cfg.calm_threshold);
			end
			default: begin
				alu_req.op = ALU_ADD;
			end
		endcase
	end

	// Sequencer and averaging state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			full_q      <= 1'b0;
			cnt_q       <= '0;
			sum_q       <= '0;
			prev_q      <= '0;
			cc_q        <= '0;
			held_avg_q  <= '0;
			held_stab_q <= '0;
			stable_q    <= 1'b0;
			div_cnt_q   <= '0;
			low_ok_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (take_in && sample.cmd) begin
						// Clear drops all averaging and stability state.
						idx_q       <= '0;
						full_q      <= 1'b0;
						sum_q       <= '0;
						prev_q      <= '0;
						cc_q        <= '0;
						held_avg_q  <= '0;
						held_stab_q <= '0;
						stable_q    <= 1'b0;
						state_q     <= S_DONE;
					end else if (take_in) begin
						state_q <= S_DIFF;
					end
				end
				S_DIFF: state_q <= S_MAGN;
				S_MAGN: state_q <= S_MUL;
				S_MUL:  state_q <= S_SAT;
				S_SAT:  state_q <= S_NEGW;
				S_NEGW: state_q <= S_LOW;
				S_LOW: begin
					low_ok_q <= !alu_rsp.neg;
					state_q  <= S_HIGH;
				end
				S_HIGH: begin
					state_q <= (low_ok_q && !alu_rsp.neg) ? S_SUB : S_DONE;
				end
				S_SUB: begin
					// Drop the oldest entry once the ring has wrapped.
					sum_q <= alu_rsp.y[SUM_W-1:0];
					if (wrap) begin
						idx_q  <= '0;
						full_q <= 1'b1;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
					if (wrap || full_q) begin
						cnt_q <= CNT_W'(AVERAGE_DEPTH);
					end else begin
						cnt_q <= CNT_W'(idx_q) + CNT_W'(1);
					end
					state_q <= S_ADD;
				end
				S_ADD: begin
					sum_q   <= alu_rsp.y[SUM_W-1:0];
					state_q <= S_ABSS;
				end
				S_ABSS: begin
					div_cnt_q <= '0;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + DCNT_W'(1);
					if (div_cnt_q == DCNT_W'(MAG_W - 1)) begin
						state_q <= S_QNEG;
					end
				end
				S_QNEG: state_q <= S_DLT;
				S_DLT:  state_q <= S_DABS;
				S_DABS: state_q <= S_CALM;
				S_CALM: begin
					cc_q       <= cc_next;
					stable_q   <= stable_next;
					prev_q     <= avg_q;
					held_avg_q <= avg_q;
					if (stable_next) begin
						held_stab_q <= avg_q;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers of the arithmetic steps.
	always_ff @(posedge clk) begin
		if (load_out) begin
			res_q <= pend_q;
		end
		case (state_q)
			S_IDLE: begin
				raw_q  <= sample.raw_sample;
				pend_q <= '0;
			end
			S_DIFF: begin
				acc_q <= alu_rsp.y;
			end
			S_MAGN: begin
				neg_q <= acc_q[ALU_W-1];
				mag_q <= acc_q[ALU_W-1] ? alu_rsp.y[DIFF_W-1:0] : acc_q[DIFF_W-1:0];
			end
			S_MUL: begin
				prod_q <= {{GAIN_W{1'b0}}, mag_q} * {{DIFF_W{1'b0}}, cfg.gain_reciprocal};
			end
			S_SAT: begin
				// The magnitude is at most 2^24 and the gain below 2^28, so the
				// scaled weight stays below 2^28 and never reaches the 32-bit limit.
				acc_q <= ALU_W'(prod_q[PROD_W-1:SMP_W]);
			end
			S_NEGW: begin
				if (neg_q) begin
					acc_q <= alu_rsp.y;
				end
			end
			S_HIGH: begin
				pend_q.accepted       <= 1'b0;
				pend_q.average_weight <= held_avg_q;
				pend_q.stable_weight  <= held_stab_q;
				pend_q.is_stable      <= stable_q;
			end
			S_ABSS: begin
				sum_neg_q <= sum_q[SUM_W-1];
				dvd_q     <= sum_q[SUM_W-1] ? alu_rsp.y[MAG_W-1:0] : sum_q[MAG_W-1:0];
				rem_q     <= '0;
			end
			S_DIV: begin
				// Restoring division of the sum magnitude by the fill count.
				if (!alu_rsp.neg) begin
					rem_q <= alu_rsp.y[CNT_W-1:0];
					dvd_q <= {dvd_q[MAG_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_shift[CNT_W-1:0];
					dvd_q <= {dvd_q[MAG_W-2:0], 1'b0};
				end
			end
			S_QNEG: begin
				avg_q <= sum_neg_q ? alu_rsp.y[WGT_W-1:0] : dvd_q[WGT_W-1:0];
			end
			S_DLT: begin
				acc_q <= alu_rsp.y;
			end
			S_DABS: begin
				if (acc_q[ALU_W-1]) begin
					acc_q <= alu_rsp.y;
				end
			end
			S_CALM: begin
				pend_q.accepted       <= 1'b1;
				pend_q.average_weight <= avg_q;
				pend_q.stable_weight  <= stable_next ? avg_q : held_stab_q;
				pend_q.is_stable      <= stable_next;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== sim/load_cell_average_stability_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the load cell averaging block: directed table, phased random traffic.
module load_cell_average_stability_tb;
	import lcas_pkg::*;

	// Register indexes of the configuration port.
	localparam int REG_TARE = 0;
	localparam int REG_GAIN = 1;
	localparam int REG_MIN  = 2;
	localparam int REG_MAX  = 3;
	localparam int REG_THR  = 4;
	localparam int REG_NEED = 5;

	// Watchdog limit and final drain; short random stalls and register writes stretch an item's time.
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 60;
	localparam int PHASES       = 8;
	localparam longint WGT_TOP  = 64'sd2147483647;

	typedef struct {
		in_item_t  stim;
		bit        typed;
		out_item_t want;
	} probe_row_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        sample_valid = 1'b0;
	logic        sample_ready;
	in_item_t    sample       = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	out_item_t   result;
	logic        psel         = 1'b0;
	logic        penable      = 1'b0;
	logic        pwrite       = 1'b0;
	logic [4:0]  paddr        = '0;
	logic [31:0] pwdata       = '0;
	logic [31:0] prdata;
	logic        pready;

	// Scale settings and averaging state as the block should hold them.
	cfg_t             scale_cfg;
	int               ring_slots [AVERAGE_DEPTH];
	logic [IDX_W-1:0] slot_ptr;
	bit               ring_wrapped;
	longint           ring_total;
	longint           last_mean;
	longint           shown_mean;
	longint           locked_weight;
	int               calm_run;
	bit               settled;

	out_item_t  pending_readings [$];
	probe_row_t probe_rows [$];
	int         mismatches  = 0;
	int         idle_cycles = 0;
	bit         steady      = 1'b0;
	int         phase_items [PHASES] = '{220, 180, 120, 300, 40, 100, 200, 180};

	load_cell_average_stability DUT (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// Settings that the block loads at reset.
	function automatic cfg_t reset_setting();
		cfg_t c;
		c.tare_offset      = '0;
		c.gain_reciprocal  = 28'd65536;
		c.min_valid_weight = -32'sd16000;
		c.max_valid_weight = 32'sd80000;
		c.calm_threshold   = 16'd8;
		c.calm_needed      = 8'd5;
		return c;
	endfunction

	function automatic void clear_scale_state();
		foreach (ring_slots[i]) ring_slots[i] = 0;
		slot_ptr      = '0;
		ring_wrapped  = 1'b0;
		ring_total    = 0;
		last_mean     = 0;
		shown_mean    = 0;
		locked_weight = 0;
		calm_run      = 0;
		settled       = 1'b0;
	endfunction

	function automatic logic signed [SMP_W-1:0] clamp_raw(longint v);
		if (v > 64'sd8388607) begin
			return 24'sh7FFFFF;
		end
		if (v < -64'sd8388608) begin
			return 24'sh800000;
		end
		return v[SMP_W-1:0];
	endfunction

	// Tare, reciprocal gain and truncation toward zero, saturated to 32 bits.
	function automatic longint scaled_weight(logic signed [SMP_W-1:0] raw);
		longint diff;
		longint mag;
		longint q;
		diff = longint'(raw) - longint'($signed(scale_cfg.tare_offset));
		mag  = (diff < 0) ? -diff : diff;
		q    = (mag * longint'(scale_cfg.gain_reciprocal)) >>> 24;
		if (q > WGT_TOP + 1) q = WGT_TOP + 1;
		if (diff < 0) begin
			return -q;
		end
		return (q > WGT_TOP) ? WGT_TOP : q;
	endfunction

	// Works out the result item of one input item and advances the averaging state.
	function automatic out_item_t weigh_item(in_item_t it);
		longint    w;
		longint    mean;
		longint    swing;
		int        fill;
		bit        took;
		out_item_t r;
		took = 1'b0;
		r    = '0;
		if (it.cmd) begin
			clear_scale_state();
		end else begin
			w = scaled_weight(it.raw_sample);
			if (w >= longint'($signed(scale_cfg.min_valid_weight)) &&
			    w <= longint'($signed(scale_cfg.max_valid_weight))) begin
				took = 1'b1;
				// The oldest entry leaves the sum only once the ring has wrapped.
				if (ring_wrapped) ring_total -= ring_slots[slot_ptr];
				ring_slots[slot_ptr] = int'(w);
				ring_total += w;
				slot_ptr = slot_ptr + 1'b1;
				if (slot_ptr == '0) ring_wrapped = 1'b1;
				fill = ring_wrapped ? AVERAGE_DEPTH : int'(slot_ptr);
				mean = ring_total / fill;
				// Calm detection on the change of the average.
				swing = mean - last_mean;
				if (swing < 0) swing = -swing;
				if (swing < longint'(scale_cfg.calm_threshold)) begin
					if (calm_run < 255) calm_run++;
				end else begin
					calm_run = 0;
				end
				last_mean  = mean;
				settled    = (calm_run >= int'(scale_cfg.calm_needed));
				shown_mean = mean;
				if (settled) locked_weight = mean;
			end
		end
		r.accepted       = took;
		r.average_weight = shown_mean[WGT_W-1:0];
		r.stable_weight  = locked_weight[WGT_W-1:0];
		r.is_stable      = settled;
		return r;
	endfunction

	function automatic probe_row_t probe(bit cmd, int raw, bit typed = 1'b0, bit took = 1'b0,
			int mean = 0, int held = 0, bit st = 1'b0);
		probe_row_t row;
		row.stim.cmd             = cmd;
		row.stim.raw_sample      = raw[SMP_W-1:0];
		row.typed                = typed;
		row.want.accepted        = took;
		row.want.average_weight  = mean;
		row.want.stable_weight   = held;
		row.want.is_stable       = st;
		return row;
	endfunction

	// Picks a raw reading that lands inside the valid weight range where one exists.
	function automatic logic signed [SMP_W-1:0] raw_near_weight();
		longint lo;
		longint hi;
		longint target;
		lo = longint'($signed(scale_cfg.min_valid_weight));
		hi = longint'($signed(scale_cfg.max_valid_weight));
		if (lo > hi || scale_cfg.gain_reciprocal == '0) begin
			return SMP_W'($urandom);
		end
		target = lo + longint'($urandom) % (hi - lo + 1);
		return clamp_raw(longint'($signed(scale_cfg.tare_offset)) +
			(target <<< 24) / longint'(scale_cfg.gain_reciprocal));
	endfunction

	// Settings of each random phase, with the register extremes spread over them.
	function automatic cfg_t pick_setting(int p);
		cfg_t c;
		c = reset_setting();
		case (p)
			1: begin
				c.tare_offset      = 24'h7FFFFF;
				c.gain_reciprocal  = GAIN_W'($urandom_range(1, 1 << 20));
				c.min_valid_weight = 32'h8000_0000;
				c.max_valid_weight = 32'h7FFF_FFFF;
				c.calm_threshold   = THR_W'($urandom_range(1, 64));
				c.calm_needed      = 8'd1;
			end
			2: begin
				c.tare_offset      = 24'h800000;
				c.gain_reciprocal  = 28'hFFF_FFFF;
				c.min_valid_weight = 32'h8000_0000;
				c.max_valid_weight = 32'h7FFF_FFFF;
				c.calm_threshold   = 16'hFFFF;
				c.calm_needed      = 8'd255;
			end
			3: begin
				c.tare_offset      = SMP_W'($urandom);
				c.gain_reciprocal  = '0;
				c.calm_threshold   = 16'hFFFF;
				c.calm_needed      = 8'd255;
			end
			4: begin
				c.tare_offset      = SMP_W'($urandom);
				c.gain_reciprocal  = 28'd1;
				c.min_valid_weight = 32'sd100;
				c.max_valid_weight = -32'sd100;
			end
			5: begin
				c.min_valid_weight = 32'h8000_0000;
				c.max_valid_weight = 32'h7FFF_FFFF;
				c.calm_threshold   = '0;
				c.calm_needed      = '0;
			end
			6: begin
				c.tare_offset      = SMP_W'($urandom);
				c.gain_reciprocal  = GAIN_W'($urandom_range(1, 28'hFFF_FFFF));
				c.min_valid_weight = -$urandom_range(0, 1 << 24);
				c.max_valid_weight = $urandom_range(0, 1 << 24);
				c.calm_threshold   = THR_W'($urandom_range(0, 300));
				c.calm_needed      = CC_W'($urandom_range(1, 20));
			end
			7: begin
				c.tare_offset      = SMP_W'($urandom_range(0, 4000) - 2000);
				c.calm_threshold   = THR_W'($urandom_range(1, 16));
			end
			default: ;
		endcase
		return c;
	endfunction

	// Offers one item, with random gaps in front, and records its expected result on acceptance.
	task automatic push_item(in_item_t it, bit typed = 1'b0, out_item_t want = '0);
		out_item_t guess;
		while (!steady && $urandom_range(99) < 10) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= it;
		@(posedge clk);
		while (!sample_ready) @(posedge clk);
		guess = weigh_item(it);
		pending_readings.push_back(typed ? want : guess);
	endtask

	task automatic drain_readings();
		while (pending_readings.size() != 0) @(posedge clk);
	endtask

	// Setup and access cycle; psel stays high so writes can follow back to back.
	task automatic write_reg(int index, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 5'(4 * index);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
	endtask

	task automatic program_scale(cfg_t c);
		write_reg(REG_TARE, {{8{c.tare_offset[SMP_W-1]}}, c.tare_offset});
		write_reg(REG_GAIN, {4'b0, c.gain_reciprocal});
		write_reg(REG_MIN, c.min_valid_weight);
		write_reg(REG_MAX, c.max_valid_weight);
		write_reg(REG_THR, {16'b0, c.calm_threshold});
		write_reg(REG_NEED, {24'b0, c.calm_needed});
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		scale_cfg = c;
	endtask

	// Runs of readings around one weight with jitter, plus stray readings and clears.
	task automatic run_phase(int n, bit clears);
		int                      sent;
		int                      run_len;
		int                      amp;
		int                      jitter;
		logic signed [SMP_W-1:0] base;
		in_item_t                it;
		sent = 0;
		while (sent < n) begin
			base    = ($urandom_range(3) == 0) ? SMP_W'($urandom) : raw_near_weight();
			run_len = $urandom_range(4, 40);
			amp     = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 600);
			for (int k = 0; k < run_len && sent < n; k++) begin
				jitter        = int'($urandom_range(0, 2 * amp)) - amp;
				it.cmd        = clears && ($urandom_range(99) < 3);
				it.raw_sample = ($urandom_range(99) < 5) ? SMP_W'($urandom) :
					clamp_raw(longint'(base) + jitter);
				push_item(it);
				sent++;
			end
		end
	endtask

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 10) $display("%s mismatch: expected %0d, got %0d", name, want, got);
		end
	endfunction

	// Result checking against the oldest expectation, and receiver stalls.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_readings.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result item %p", result);
			end else begin
				want = pending_readings.pop_front();
				check_field("accepted", want.accepted, result.accepted);
				check_field("average_weight", want.average_weight, result.average_weight);
				check_field("stable_weight", want.stable_weight, result.stable_weight);
				check_field("is_stable", want.is_stable, result.is_stable);
			end
		end
		result_ready <= steady || ($urandom_range(99) >= 10);
	end

	// Watchdog on cycles in which no item moves on either channel.
	always @(posedge clk) begin
		if ((sample_valid && sample_ready) || (result_valid && result_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("load_cell_average_stability test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		scale_cfg = reset_setting();
		clear_scale_state();

		// Directed rows at the reset settings; zero-weight readings settle after five calm items.
		probe_rows.push_back(probe(1, 8388607, 1, 0, 0, 0, 0));
		probe_rows.push_back(probe(0, -8388608, 1, 0, 0, 0, 0));
		probe_rows.push_back(probe(0, 0, 1, 1, 0, 0, 0));
		probe_rows.push_back(probe(0, 255, 1, 1, 0, 0, 0));
		probe_rows.push_back(probe(0, -255, 1, 1, 0, 0, 0));
		probe_rows.push_back(probe(0, 0, 1, 1, 0, 0, 0));
		probe_rows.push_back(probe(0, 0, 1, 1, 0, 0, 1));
		// A full-scale step breaks stability; then alternating bit patterns and range edges.
		probe_rows.push_back(probe(0, 8388607));
		probe_rows.push_back(probe(0, -8388608));
		probe_rows.push_back(probe(0, 5592405));
		probe_rows.push_back(probe(0, -5592406));
		probe_rows.push_back(probe(0, 4096000));
		probe_rows.push_back(probe(0, -4096000));
		probe_rows.push_back(probe(0, -4096256));
		probe_rows.push_back(probe(0, 1));
		probe_rows.push_back(probe(1, 0, 1, 0, 0, 0, 0));
		probe_rows.push_back(probe(0, -1, 1, 1, 0, 0, 0));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (probe_rows[i]) push_item(probe_rows[i].stim, probe_rows[i].typed, probe_rows[i].want);

		// Each phase starts with the block drained and a fresh set of registers.
		for (int p = 0; p < PHASES; p++) begin
			sample_valid <= 1'b0;
			drain_readings();
			program_scale(pick_setting(p));
			steady = (p == 3);
			run_phase(phase_items[p], p != 3);
		end

		sample_valid <= 1'b0;
		steady = 1'b0;
		drain_readings();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("load_cell_average_stability test passed");
		end else begin
			$display("load_cell_average_stability test failed");
		end
		$finish;
	end

endmodule
